// ----- rtl/core/prdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package prdt_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 48;
    localparam int CW    = 7;

    typedef logic [CW-1:0] cnt_t;
    typedef logic [3:0]    flags_t;
    typedef logic [5:0]    runs_t;

    // flag bit positions
    localparam int FB_NRES  = 0;
    localparam int FB_NCHG  = 1;
    localparam int FB_DISK  = 2;
    localparam int FB_DIRTY = 3;

    localparam flags_t FLAGS_RESET = 4'b0011;
    localparam flags_t FLAGS_WBACK = 4'b0111;
    localparam flags_t FLAGS_DIRTY = 4'b1000;

    localparam runs_t RUN_CAP = 6'd32;

    localparam logic REG_PAGE_COUNT = 1'b0;
    localparam logic REG_LAZY_READ  = 1'b1;

    localparam cnt_t PAGE_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_FAULT    = 2'd0,
        OP_SWAP_IN  = 2'd1,
        OP_SWAP_OUT = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FETCH = 2'd0,
        KIND_WBACK = 2'd1,
        KIND_LOAD  = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE        = 2'd0,
        STAT_SKIP        = 2'd1,
        STAT_BAD         = 2'd2,
        STAT_DIRTY_FAULT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FAULT,
        ST_WALK,
        ST_DONE
    } state_t;

    function automatic cnt_t dec_sat(cnt_t v, cnt_t n);
        return (v > n) ? cnt_t'(v - n) : '0;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/page_residency_dirty_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: opcode, first_page, page_span
// m_        out  m_tvalid/m_tready  m_tdata: result fields, m_tlast: last
// cfg_      in   cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// a range command handles one page per cycle, reading the next flag entry while writing the current
// one; the walk holds while a run word waits for m_tready, and a fault or a command end holds while
// its load or completion word waits.
// reset is synchronous; per-page valid bits make the flag store read as
// nonresident and uncharged at once, with no clearing pass.
// s_tready is high only between commands.

module page_residency_dirty_tracker
    import prdt_pkg::*;
#(
    parameter int MAX_PAGES = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // opcode[1:0], first_page[7:2], page_span[14:8]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // result_kind[1:0], run_start[7:2],
                                             // run_length[14:8], pages_moved[21:15],
                                             // loaded_total[28:22], charged_total[35:29],
                                             // dirty_total[42:36], status[44:43]
    output logic                  m_tlast,
    input  wire logic             cfg_wr_en,
    input  wire logic [0:0]       cfg_wr_index,
    input  wire logic [CW-1:0]    cfg_wr_data
);

    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam cnt_t MAX_CNT = cnt_t'(MAX_PAGES);

    state_t state_reg, state_next;

    opcode_t     op_reg, op_next;
    logic [5:0]  beg_reg, beg_next;
    cnt_t        num_reg, num_next;
    logic [PW-1:0] ip_reg, ip_next;
    logic [PW-1:0] end_reg, end_next;
    logic [PW-1:0] first_reg, first_next;
    logic        open_reg, open_next;
    runs_t       runs_reg, runs_next;
    cnt_t        moved_reg, moved_next;
    status_t     status_reg, status_next;

    cnt_t loaded_reg, loaded_next;
    cnt_t charged_reg, charged_next;
    cnt_t dirty_reg, dirty_next;

    cnt_t page_count_reg;
    logic lazy_reg;

    // flag store
    flags_t               flag_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] vld_reg;
    flags_t               rd_data_reg;
    logic                 rd_vld_reg;
    cnt_t                 rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    flags_t               wr_data;

    // output word
    logic       m_tvalid_reg, m_tvalid_next;
    kind_t      o_kind_reg;
    logic [5:0] o_start_reg;
    cnt_t       o_len_reg, o_moved_reg, o_loaded_reg, o_charged_reg, o_dirty_reg;
    status_t    o_status_reg;
    logic       o_last_reg;

    logic       emit;
    kind_t      e_kind;
    logic [5:0] e_start;
    cnt_t       e_len;
    logic       out_free;

    cnt_t          cnt;
    flags_t        f_rd, f_walk;
    logic          at_end, want, close, need_emit, walk_stall;
    logic          beg_ok, range_bad, chk_skip, accept;
    logic [PW-1:0] run_diff, ip_inc;
    cnt_t          run_len, first_ext;
    logic [7:0]    range_end;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_status_reg, o_dirty_reg, o_charged_reg, o_loaded_reg,
                       o_moved_reg, o_len_reg, o_start_reg, o_kind_reg};

    // shared decisions
    always_comb begin
        cnt       = (page_count_reg > MAX_CNT) ? MAX_CNT : page_count_reg;
        f_rd      = rd_vld_reg ? rd_data_reg : FLAGS_RESET;
        at_end    = (ip_reg == end_reg);
        f_walk    = at_end ? flags_t'(0) : f_rd;
        ip_inc    = ip_reg + 1'b1;
        run_diff  = ip_reg - first_reg;
        run_len   = cnt_t'(run_diff);
        first_ext = cnt_t'(first_reg);
        beg_ok    = (cnt_t'(beg_reg) < cnt);
        range_end = 8'(beg_reg) + 8'(num_reg);
        range_bad = (range_end > 8'(cnt));
        unique case (op_reg)
            OP_SWAP_IN:  want = f_walk[FB_NRES] && f_walk[FB_DISK] && !f_walk[FB_DIRTY];
            OP_SWAP_OUT: want = f_walk[FB_DIRTY];
            default:     want = 1'b0;
        endcase
        close      = open_reg && !want;
        need_emit  = close && (runs_reg < RUN_CAP);
        walk_stall = need_emit && !out_free;
        chk_skip   = (num_reg == '0)
                  || ((op_reg == OP_SWAP_IN) && (loaded_reg == cnt))
                  || ((op_reg != OP_SWAP_IN) && (dirty_reg == '0));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (op_reg == OP_FAULT) begin
                    state_next = beg_ok ? ST_FAULT : ST_DONE;
                end else begin
                    state_next = (range_bad || chk_skip) ? ST_DONE : ST_WALK;
                end
            end
            ST_FAULT: begin
                if (!(f_rd[FB_NRES] && !out_free)) state_next = ST_DONE;
            end
            ST_WALK: begin
                if (at_end && !walk_stall) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next      = op_reg;
        beg_next     = beg_reg;
        num_next     = num_reg;
        ip_next      = ip_reg;
        end_next     = end_reg;
        first_next   = first_reg;
        open_next    = open_reg;
        runs_next    = runs_reg;
        moved_next   = moved_reg;
        status_next  = status_reg;
        loaded_next  = loaded_reg;
        charged_next = charged_reg;
        dirty_next   = dirty_reg;
        wr_en        = 1'b0;
        wr_addr      = ip_reg[AW-1:0];
        wr_data      = f_walk;
        rd_addr      = cnt_t'(ip_reg);
        emit         = 1'b0;
        e_kind       = KIND_DONE;
        e_start      = '0;
        e_len        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = opcode_t'(s_tdata[1:0]);
                    beg_next   = s_tdata[7:2];
                    num_next   = s_tdata[14:8];
                    moved_next = '0;
                end
            end
            ST_CHECK: begin
                rd_addr     = cnt_t'(beg_reg);
                status_next = STAT_DONE;
                ip_next     = PW'(beg_reg);
                end_next    = PW'(range_end);
                open_next   = 1'b0;
                runs_next   = '0;
                if (op_reg == OP_FAULT) begin
                    if (!beg_ok) status_next = STAT_BAD;
                end else if (range_bad) begin
                    status_next = STAT_BAD;
                end else if (chk_skip) begin
                    status_next = STAT_SKIP;
                end
            end
            ST_FAULT: begin
                rd_addr = cnt_t'(beg_reg);
                wr_addr = beg_reg[AW-1:0];
                wr_data = FLAGS_DIRTY;
                if (f_rd[FB_NRES]) begin
                    emit    = 1'b1;
                    e_kind  = KIND_LOAD;
                    e_start = lazy_reg ? beg_reg : 6'd0;
                    e_len   = lazy_reg ? cnt_t'(1) : cnt;
                end else if (f_rd[FB_DIRTY]) begin
                    status_next = STAT_DIRTY_FAULT;
                end else begin
                    wr_en      = 1'b1;
                    dirty_next = dirty_reg + 1'b1;
                end
            end
            ST_WALK: begin
                rd_addr = walk_stall ? cnt_t'(ip_reg) : cnt_t'(ip_inc);
                emit    = need_emit;
                e_kind  = (op_reg == OP_SWAP_IN) ? KIND_FETCH : KIND_WBACK;
                e_start = first_ext[5:0];
                e_len   = run_len;
                if (!walk_stall) begin
                    if (!at_end) ip_next = ip_inc;
                    open_next = want;
                    if (want && !open_reg) first_next = ip_reg;
                    if (close) begin
                        if (runs_reg < RUN_CAP) runs_next = runs_reg + 1'b1;
                        moved_next = moved_reg + run_len;
                        if (op_reg == OP_SWAP_OUT) dirty_next = dec_sat(dirty_reg, run_len);
                    end
                    if (!at_end) begin
                        unique case (op_reg)
                            OP_SWAP_IN: begin
                                if (f_walk[FB_NRES]) begin
                                    wr_en       = 1'b1;
                                    wr_data     = f_walk & ~FLAGS_RESET;
                                    loaded_next = loaded_reg + 1'b1;
                                    if (f_walk[FB_NCHG]) charged_next = charged_reg + 1'b1;
                                end
                            end
                            OP_SWAP_OUT: begin
                                wr_en   = 1'b1;
                                wr_data = f_walk[FB_DIRTY] ? FLAGS_WBACK
                                        : ((f_walk & FLAGS_WBACK) | FLAGS_RESET);
                                if (!f_walk[FB_NCHG]) begin
                                    if (!f_walk[FB_NRES])
                                        loaded_next = dec_sat(loaded_reg, cnt_t'(1));
                                    charged_next = dec_sat(charged_reg, cnt_t'(1));
                                end
                            end
                            OP_CLEAR: begin
                                wr_en   = 1'b1;
                                wr_data = f_walk & FLAGS_RESET;
                                if (f_walk[FB_DIRTY]) dirty_next = dec_sat(dirty_reg, cnt_t'(1));
                            end
                            OP_FAULT: begin
                                wr_en = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_DONE: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign rd_en = (rd_addr < MAX_CNT);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            loaded_reg     <= '0;
            charged_reg    <= '0;
            dirty_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            page_count_reg <= PAGE_COUNT_RST;
            lazy_reg       <= 1'b0;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            charged_reg  <= charged_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_PAGE_COUNT) page_count_reg <= cfg_wr_data;
                if (cfg_wr_index == REG_LAZY_READ)  lazy_reg       <= cfg_wr_data[0];
            end
            if (wr_en) vld_reg[wr_addr] <= 1'b1;
            if (rd_en) rd_vld_reg <= vld_reg[rd_addr[AW-1:0]];
        end
    end

    // command context and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runs_reg <= '0;
        end else begin
            runs_reg <= runs_next;
        end
        op_reg     <= op_next;
        beg_reg    <= beg_next;
        num_reg    <= num_next;
        ip_reg     <= ip_next;
        end_reg    <= end_next;
        first_reg  <= first_next;
        open_reg   <= open_next;
        moved_reg  <= moved_next;
        status_reg <= status_next;
        if (emit && out_free) begin
            o_kind_reg    <= e_kind;
            o_start_reg   <= e_start;
            o_len_reg     <= e_len;
            o_last_reg    <= (e_kind == KIND_DONE);
            o_moved_reg   <= (e_kind == KIND_DONE) ? moved_reg   : cnt_t'(0);
            o_loaded_reg  <= (e_kind == KIND_DONE) ? loaded_reg  : cnt_t'(0);
            o_charged_reg <= (e_kind == KIND_DONE) ? charged_reg : cnt_t'(0);
            o_dirty_reg   <= (e_kind == KIND_DONE) ? dirty_reg   : cnt_t'(0);
            o_status_reg  <= (e_kind == KIND_DONE) ? status_reg  : STAT_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) flag_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= flag_mem[rd_addr[AW-1:0]];
    end

    a_last_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (o_kind_reg == KIND_DONE)))
        else $error("last flag does not match completion word");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (loaded_reg <= MAX_CNT) && (charged_reg <= MAX_CNT) && (dirty_reg <= MAX_CNT))
        else $error("page counter beyond allocation size");

    a_runs_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        runs_reg <= RUN_CAP)
        else $error("run counter beyond cap");

    a_stall_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && walk_stall) |-> !wr_en)
        else $error("flag write while walk is stalled");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CHECK))
        else $error("accepted word did not start a check");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import prdt_pkg::*;

    localparam int MAX_PAGES = 64;

    typedef struct packed {
        logic       last;
        status_t    status;
        cnt_t       dirty;
        cnt_t       charged;
        cnt_t       loaded;
        cnt_t       moved;
        cnt_t       run_length;
        logic [5:0] run_start;
        kind_t      kind;
    } page_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic [0:0]        cfg_wr_index = '0;
    logic [CW-1:0]     cfg_wr_data = '0;

    // shadow copy of the tracker state
    flags_t        page_state [MAX_PAGES] = '{default: FLAGS_RESET};
    int            loaded_cnt = 0;
    int            charged_cnt = 0;
    int            dirty_cnt = 0;
    int            cfg_pages = 64;
    bit            cfg_lazy = 1'b0;

    page_result_t  pending_results [$];
    int            mismatch_count = 0;
    int            hold_req = 0;
    bit            tx_steady = 1'b0;

    page_residency_dirty_tracker #(.MAX_PAGES(MAX_PAGES)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int sat_sub(int v, int n);
        return (v > n) ? v - n : 0;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 45);
    endfunction

    function automatic string fmt_word(page_result_t w);
        return $sformatf("kind=%0d start=%0d len=%0d moved=%0d ld=%0d chg=%0d drt=%0d st=%0d last=%0d",
                         w.kind, w.run_start, w.run_length, w.moved, w.loaded, w.charged,
                         w.dirty, w.status, w.last);
    endfunction

    function automatic void push_run(kind_t k, int start, int len);
        page_result_t w;
        w = '0;
        w.kind = k;
        w.run_start = start[5:0];
        w.run_length = len[6:0];
        pending_results.push_back(w);
    endfunction

    function automatic void push_done(int moved, status_t st);
        page_result_t w;
        w = '0;
        w.kind = KIND_DONE;
        w.moved = moved[6:0];
        w.loaded = loaded_cnt[6:0];
        w.charged = charged_cnt[6:0];
        w.dirty = dirty_cnt[6:0];
        w.status = st;
        w.last = 1'b1;
        pending_results.push_back(w);
    endfunction

    // updates the shadow state and queues the words one command produces
    function automatic void apply_page_command(opcode_t op, int beg, int span);
        int     cnt, stop, first, moved, runs;
        bit     open, want;
        flags_t f;
        cnt = (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
        moved = 0;
        runs = 0;
        open = 1'b0;
        first = 0;
        if (op == OP_FAULT) begin
            if (beg >= cnt) begin
                push_done(0, STAT_BAD);
            end else if (page_state[beg][FB_NRES]) begin
                if (cfg_lazy) push_run(KIND_LOAD, beg, 1);
                else push_run(KIND_LOAD, 0, cnt);
                push_done(0, STAT_DONE);
            end else if (page_state[beg][FB_DIRTY]) begin
                push_done(0, STAT_DIRTY_FAULT);
            end else begin
                page_state[beg] = FLAGS_DIRTY;
                dirty_cnt++;
                push_done(0, STAT_DONE);
            end
            return;
        end
        if (span > cnt || beg > cnt - span) begin
            push_done(0, STAT_BAD);
            return;
        end
        if (span == 0) begin
            push_done(0, STAT_SKIP);
            return;
        end
        stop = beg + span;
        if (op == OP_SWAP_IN) begin
            if (loaded_cnt == cnt) begin
                push_done(0, STAT_SKIP);
                return;
            end
            for (int p = beg; p <= stop; p++) begin
                f = (p < stop) ? page_state[p] : '0;
                want = (p < stop) && f[FB_NRES] && f[FB_DISK] && !f[FB_DIRTY];
                if (want) begin
                    if (!open) begin
                        open = 1'b1;
                        first = p;
                    end
                end else if (open) begin
                    if (runs < RUN_CAP) push_run(KIND_FETCH, first, p - first);
                    runs++;
                    moved += p - first;
                    open = 1'b0;
                end
                if (p < stop && f[FB_NRES]) begin
                    loaded_cnt++;
                    if (f[FB_NCHG]) charged_cnt++;
                    page_state[p] = f & ~FLAGS_RESET;
                end
            end
            push_done(moved, STAT_DONE);
            return;
        end
        if (dirty_cnt == 0) begin
            push_done(0, STAT_SKIP);
            return;
        end
        if (op == OP_SWAP_OUT) begin
            for (int p = beg; p <= stop; p++) begin
                f = (p < stop) ? page_state[p] : '0;
                if (p < stop && !f[FB_NCHG]) begin
                    if (!f[FB_NRES]) loaded_cnt = sat_sub(loaded_cnt, 1);
                    charged_cnt = sat_sub(charged_cnt, 1);
                end
                if (p < stop && f[FB_DIRTY]) begin
                    if (!open) begin
                        open = 1'b1;
                        first = p;
                    end
                    page_state[p] = FLAGS_WBACK;
                end else begin
                    if (p < stop) page_state[p] = (f & (flags_t'(1) << FB_DISK)) | FLAGS_RESET;
                    if (open) begin
                        if (runs < RUN_CAP) push_run(KIND_WBACK, first, p - first);
                        runs++;
                        moved += p - first;
                        dirty_cnt = sat_sub(dirty_cnt, p - first);
                        open = 1'b0;
                    end
                end
            end
            push_done(moved, STAT_DONE);
            return;
        end
        for (int p = beg; p < stop; p++) begin
            if (page_state[p][FB_DIRTY]) dirty_cnt = sat_sub(dirty_cnt, 1);
            page_state[p] = page_state[p] & FLAGS_RESET;
        end
        push_done(0, STAT_DONE);
    endfunction

    // result side: random stalls, long hold on request, compare each word
    initial begin
        page_result_t got, want;
        int  stall_left;
        int  hold_left;
        bit  rx_steady;
        stall_left = 0;
        hold_left = 0;
        rx_steady = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = page_result_t'({m_tlast, m_tdata[44:0]});
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: %s", fmt_word(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch expected: %s", fmt_word(want));
                            $display("         actual:   %s", fmt_word(got));
                        end
                    end
                end
            end
            if ($urandom_range(0, 399) == 0) rx_steady = !rx_steady;
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = gap_len();
            end
        end
    end

    task automatic send_command(opcode_t op, int beg, int span);
        int gap;
        if ($urandom_range(0, 99) < 3) tx_steady = !tx_steady;
        gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, span[6:0], beg[5:0], op};
        do @(posedge aclk); while (!s_tready);
        apply_page_command(op, beg, span);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(int pages, bit lazy);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= REG_PAGE_COUNT;
        cfg_wr_data <= pages[6:0];
        @(posedge aclk);
        cfg_wr_index <= REG_LAZY_READ;
        cfg_wr_data <= {6'd0, lazy};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cfg_pages = pages & 127;
        cfg_lazy = lazy;
    endtask

    // mostly well-formed commands inside the allocation, some raw noise
    task automatic send_random_command();
        int      cnt, beg, span, r;
        opcode_t op;
        cnt = (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
        r = $urandom_range(0, 99);
        if (r < 8 || cnt == 0) begin
            send_command(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 127));
        end else begin
            r = $urandom_range(0, 99);
            op = (r < 38) ? OP_FAULT : (r < 64) ? OP_SWAP_IN : (r < 92) ? OP_SWAP_OUT : OP_CLEAR;
            if (op == OP_FAULT) begin
                send_command(op, $urandom_range(0, cnt - 1), $urandom_range(0, 127));
            end else begin
                if ($urandom_range(0, 1)) span = $urandom_range(1, (cnt < 8) ? cnt : 8);
                else span = $urandom_range(1, cnt);
                beg = $urandom_range(0, cnt - span);
                send_command(op, beg, span);
            end
        end
    endtask

    task automatic test_range_rejects();
        send_command(OP_SWAP_OUT, 0, 10);
        send_command(OP_CLEAR, 0, 64);
        send_command(OP_SWAP_IN, 0, 0);
        send_command(OP_SWAP_IN, 0, 65);
        send_command(OP_SWAP_IN, 63, 2);
        send_command(OP_SWAP_OUT, 0, 127);
    endtask

    task automatic test_page_faults();
        send_command(OP_FAULT, 63, 0);
        send_command(OP_SWAP_IN, 0, 64);
        send_command(OP_SWAP_IN, 10, 5);
        send_command(OP_FAULT, 5, 127);
        send_command(OP_FAULT, 6, 0);
        send_command(OP_FAULT, 7, 0);
        send_command(OP_FAULT, 63, 0);
        send_command(OP_FAULT, 5, 0);
    endtask

    task automatic test_writeback_fetch();
        send_command(OP_SWAP_OUT, 0, 64);
        set_config(64, 1'b1);
        send_command(OP_FAULT, 6, 0);
        send_command(OP_SWAP_IN, 0, 64);
        send_command(OP_FAULT, 63, 0);
        send_command(OP_FAULT, 0, 0);
        send_command(OP_CLEAR, 0, 64);
        send_command(OP_SWAP_OUT, 0, 64);
    endtask

    task automatic test_small_allocations();
        set_config(10, 1'b0);
        send_command(OP_FAULT, 10, 0);
        send_command(OP_SWAP_IN, 5, 6);
        send_command(OP_FAULT, 9, 0);
        set_config(0, 1'b0);
        send_command(OP_FAULT, 0, 0);
        send_command(OP_SWAP_IN, 0, 0);
        send_command(OP_CLEAR, 0, 1);
    endtask

    task automatic test_random_traffic(int pages, bit lazy, int n);
        set_config(pages, lazy);
        repeat (n) send_random_command();
    endtask

    // results held back long enough that the tracker stalls its input
    task automatic test_output_backpressure();
        set_config(64, 1'b0);
        hold_req = 300;
        repeat (14) send_random_command();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_range_rejects();
        test_page_faults();
        test_writeback_fetch();
        test_small_allocations();
        test_random_traffic(64, 1'b0, 100);
        test_output_backpressure();
        test_random_traffic(16, 1'b1, 85);
        test_random_traffic(127, 1'b1, 70);
        test_random_traffic(5, 1'b0, 55);
        test_random_traffic(1, 1'b1, 30);
        test_random_traffic(0, 1'b0, 10);
        test_random_traffic(40, 1'b0, 60);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
